[design/class_file_constant_pool_parser_top_assert.svh]
// assertion macros shared by the parser modules
`ifndef CLASS_FILE_CONSTANT_POOL_PARSER_TOP_ASSERT_SVH
`define CLASS_FILE_CONSTANT_POOL_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define CFCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cfcp_pkg.sv]
package cfcp_pkg;

    localparam int unsigned POOL_ENTRIES_DEFAULT = 4096;
    localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

    // result kinds
    localparam logic [2:0] KIND_TEXT_HDR  = 3'd0;
    localparam logic [2:0] KIND_TEXT_BYTE = 3'd1;
    localparam logic [2:0] KIND_CLASS     = 3'd2;
    localparam logic [2:0] KIND_NAMETYPE  = 3'd3;
    localparam logic [2:0] KIND_THIS      = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;

    // error codes
    localparam logic [2:0] ERR_BAD_TAG   = 3'd0;
    localparam logic [2:0] ERR_RANGE     = 3'd1;
    localparam logic [2:0] ERR_TRUNC     = 3'd2;
    localparam logic [2:0] ERR_NOT_CLASS = 3'd3;
    localparam logic [2:0] ERR_TOO_BIG   = 3'd4;

    // pool tags
    localparam logic [7:0] TAG_UTF8      = 8'd1;
    localparam logic [7:0] TAG_INTEGER   = 8'd3;
    localparam logic [7:0] TAG_FLOAT     = 8'd4;
    localparam logic [7:0] TAG_LONG      = 8'd5;
    localparam logic [7:0] TAG_DOUBLE    = 8'd6;
    localparam logic [7:0] TAG_CLASS     = 8'd7;
    localparam logic [7:0] TAG_STRING    = 8'd8;
    localparam logic [7:0] TAG_FIELDREF  = 8'd9;
    localparam logic [7:0] TAG_METHODREF = 8'd10;
    localparam logic [7:0] TAG_IFACEREF  = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE  = 8'd12;

    typedef enum logic [2:0] {
        TC_TEXT,
        TC_SKIP2,
        TC_SKIP4,
        TC_SKIP8,
        TC_CLASS,
        TC_NAMETYPE,
        TC_BAD
    } tag_class_t;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_VERSION,
        PH_COUNT,
        PH_TAG,
        PH_SKIP,
        PH_TEXT_LEN,
        PH_TEXT_BYTES,
        PH_CLASS,
        PH_NAMETYPE,
        PH_FLAGS,
        PH_THIS,
        PH_LOOKUP
    } phase_t;

    // one classified stream byte
    typedef struct packed {
        logic [7:0] data;
        logic       end_mark;
        tag_class_t tag_class;
    } item_t;

endpackage

[design/cfcp_front.sv]
module cfcp_front
    import cfcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_mark,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    `include "class_file_constant_pool_parser_top_assert.svh"

    localparam int QUEUE_DEPTH = 2;

    item_t      slot_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      new_item;
    logic       push, pop;

    // tag classification of the incoming byte
    always_comb
    begin
        new_item.data     = data_byte;
        new_item.end_mark = end_mark;
        unique case (data_byte) inside
            TAG_UTF8:                               new_item.tag_class = TC_TEXT;
            TAG_STRING:                             new_item.tag_class = TC_SKIP2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF,
            TAG_METHODREF, TAG_IFACEREF:            new_item.tag_class = TC_SKIP4;
            TAG_LONG, TAG_DOUBLE:                   new_item.tag_class = TC_SKIP8;
            TAG_CLASS:                              new_item.tag_class = TC_CLASS;
            TAG_NAMETYPE:                           new_item.tag_class = TC_NAMETYPE;
            default:                                new_item.tag_class = TC_BAD;
        endcase
    end

    // queue handshake
    assign in_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    `CFCP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= 2'(QUEUE_DEPTH), "queue overfilled")
    `CFCP_ASSERT_NEXT(a_push_lands, push && !pop, count_reg == $past(count_reg) + 2'd1,
        "push lost")
    `CFCP_ASSERT_NOW(a_ptr_match, count_reg == 2'd0 || count_reg == 2'd2,
        wr_ptr_reg == rd_ptr_reg, "queue pointers out of step")

endmodule

[design/cfcp_back.sv]
module cfcp_back
    import cfcp_pkg::*;
#(
    parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [11:0] entry_index,
    output logic [15:0] value,
    output logic [2:0]  error_code
);

    `include "class_file_constant_pool_parser_top_assert.svh"

    localparam int AW = $clog2(POOL_ENTRIES);
    localparam logic [16:0] POOL_LIMIT = 17'(POOL_ENTRIES);

    // class table memory
    logic [AW-1:0] table_mem [POOL_ENTRIES];
    logic [AW-1:0] rdata_reg;
    logic          we;
    logic [AW-1:0] waddr, wdata, raddr;

    phase_t      phase_reg, phase_next;
    logic [31:0] window_reg, window_next;
    logic [15:0] bc_reg, bc_next;
    logic [AW:0] cur_reg, cur_next;
    logic [AW:0] pool_reg, pool_next;
    logic        long_reg, long_next;
    logic [15:0] fv_reg, fv_next;

    logic        ov_reg, ov_next;
    logic [2:0]  kind_reg, kind_next;
    logic [11:0] idx_reg, idx_next;
    logic [15:0] val_reg, val_next;
    logic [2:0]  err_reg, err_next;

    logic        step;
    logic [15:0] fv_shift;
    logic [16:0] pool17;
    logic [AW:0] cur_plus1;
    logic [AW:0] fin_entry;

    assign step     = (q_valid || phase_reg == PH_LOOKUP) && (!ov_reg || out_ready);
    assign q_ready  = step && (phase_reg != PH_LOOKUP);
    assign fv_shift = {fv_reg[7:0], q_item.data};
    assign pool17   = 17'(pool_reg);
    assign cur_plus1 = cur_reg + (AW+1)'(1);

    // parser step
    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        bc_next     = bc_reg;
        cur_next    = cur_reg;
        pool_next   = pool_reg;
        long_next   = long_reg;
        fv_next     = fv_reg;
        ov_next     = ov_reg && !out_ready;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        err_next    = err_reg;
        we          = 1'b0;
        waddr       = cur_reg[AW-1:0];
        wdata       = '0;
        // hold the this_class address while the lookup waits
        raddr       = (phase_reg == PH_LOOKUP) ? fv_reg[AW-1:0] : fv_shift[AW-1:0];
        fin_entry   = cur_plus1;

        if (step)
        begin
            if (phase_reg == PH_LOOKUP)
            begin
                ov_next     = 1'b1;
                idx_next    = 12'(fv_reg);
                err_next    = ERR_BAD_TAG;
                phase_next  = PH_HUNT;
                window_next = '0;
                bc_next     = '0;
                if (fv_reg == 16'd0 || rdata_reg == '0)
                begin
                    kind_next = KIND_ERROR;
                    val_next  = '0;
                    err_next  = ERR_NOT_CLASS;
                end
                else
                begin
                    kind_next = KIND_THIS;
                    val_next  = 16'(rdata_reg);
                end
            end
            else if (q_item.end_mark)
            begin
                window_next = '0;
                if (phase_reg != PH_HUNT)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_ERROR;
                    idx_next   = 12'(cur_reg);
                    val_next   = '0;
                    err_next   = ERR_TRUNC;
                    phase_next = PH_HUNT;
                    bc_next    = '0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        window_next = {window_reg[23:0], q_item.data};
                        if ({window_reg[23:0], q_item.data} == MAGIC_WORD)
                        begin
                            phase_next = PH_VERSION;
                            bc_next    = '0;
                            cur_next   = '0;
                            fv_next    = '0;
                        end
                    end
                    PH_VERSION:
                    begin
                        bc_next = bc_reg + 16'd1;
                        if (bc_reg == 16'd3)
                        begin
                            phase_next = PH_COUNT;
                            bc_next    = '0;
                            fv_next    = '0;
                        end
                    end
                    PH_COUNT:
                    begin
                        fv_next = fv_shift;
                        bc_next = bc_reg + 16'd1;
                        if (bc_reg == 16'd1)
                        begin
                            if ({1'b0, fv_shift} > POOL_LIMIT)
                            begin
                                pool_next   = '0;
                                ov_next     = 1'b1;
                                kind_next   = KIND_ERROR;
                                idx_next    = '0;
                                val_next    = '0;
                                err_next    = ERR_TOO_BIG;
                                phase_next  = PH_HUNT;
                                window_next = '0;
                                bc_next     = '0;
                            end
                            else
                            begin
                                pool_next  = (AW+1)'(fv_shift);
                                cur_next   = (AW+1)'(1);
                                bc_next    = '0;
                                fv_next    = '0;
                                phase_next = (fv_shift <= 16'd1) ? PH_FLAGS : PH_TAG;
                            end
                        end
                    end
                    PH_TAG:
                    begin
                        we        = 1'b1;
                        bc_next   = '0;
                        fv_next   = '0;
                        long_next = 1'b0;
                        case (q_item.tag_class)
                            TC_TEXT:     phase_next = PH_TEXT_LEN;
                            TC_SKIP2:
                            begin
                                bc_next    = 16'd2;
                                phase_next = PH_SKIP;
                            end
                            TC_SKIP4:
                            begin
                                bc_next    = 16'd4;
                                phase_next = PH_SKIP;
                            end
                            TC_SKIP8:
                            begin
                                bc_next    = 16'd8;
                                long_next  = 1'b1;
                                phase_next = PH_SKIP;
                            end
                            TC_CLASS:    phase_next = PH_CLASS;
                            TC_NAMETYPE: phase_next = PH_NAMETYPE;
                            default:
                            begin
                                ov_next     = 1'b1;
                                kind_next   = KIND_ERROR;
                                idx_next    = 12'(cur_reg);
                                val_next    = 16'(q_item.data);
                                err_next    = ERR_BAD_TAG;
                                phase_next  = PH_HUNT;
                                window_next = '0;
                            end
                        endcase
                    end
                    PH_SKIP:
                    begin
                        // second slot of a long or double is cleared here
                        if (long_reg && bc_reg == 16'd8 && 17'(cur_plus1) < pool17)
                        begin
                            we    = 1'b1;
                            waddr = cur_plus1[AW-1:0];
                        end
                        bc_next = bc_reg - 16'd1;
                        if (bc_reg == 16'd1)
                        begin
                            fin_entry  = long_reg ? cur_reg + (AW+1)'(2) : cur_plus1;
                            cur_next   = fin_entry;
                            bc_next    = '0;
                            fv_next    = '0;
                            phase_next = (fin_entry >= pool_reg) ? PH_FLAGS : PH_TAG;
                        end
                    end
                    PH_TEXT_LEN:
                    begin
                        fv_next = fv_shift;
                        bc_next = bc_reg + 16'd1;
                        if (bc_reg == 16'd1)
                        begin
                            ov_next   = 1'b1;
                            kind_next = KIND_TEXT_HDR;
                            idx_next  = 12'(cur_reg);
                            val_next  = fv_shift;
                            err_next  = ERR_BAD_TAG;
                            if (fv_shift == 16'd0)
                            begin
                                cur_next   = cur_plus1;
                                bc_next    = '0;
                                fv_next    = '0;
                                phase_next = (cur_plus1 >= pool_reg) ? PH_FLAGS : PH_TAG;
                            end
                            else
                            begin
                                bc_next    = fv_shift;
                                phase_next = PH_TEXT_BYTES;
                            end
                        end
                    end
                    PH_TEXT_BYTES:
                    begin
                        ov_next   = 1'b1;
                        kind_next = KIND_TEXT_BYTE;
                        idx_next  = 12'(cur_reg);
                        val_next  = 16'(q_item.data);
                        err_next  = ERR_BAD_TAG;
                        bc_next   = bc_reg - 16'd1;
                        if (bc_reg == 16'd1)
                        begin
                            cur_next   = cur_plus1;
                            bc_next    = '0;
                            fv_next    = '0;
                            phase_next = (cur_plus1 >= pool_reg) ? PH_FLAGS : PH_TAG;
                        end
                    end
                    PH_CLASS, PH_NAMETYPE:
                    begin
                        fv_next = fv_shift;
                        bc_next = bc_reg + 16'd1;
                        if ((phase_reg == PH_CLASS && bc_reg == 16'd1) ||
                            (phase_reg == PH_NAMETYPE && bc_reg == 16'd3))
                        begin
                            ov_next  = 1'b1;
                            idx_next = 12'(cur_reg);
                            val_next = fv_shift;
                            if ({1'b0, fv_shift} >= pool17)
                            begin
                                kind_next   = KIND_ERROR;
                                err_next    = ERR_RANGE;
                                phase_next  = PH_HUNT;
                                window_next = '0;
                                bc_next     = '0;
                            end
                            else
                            begin
                                kind_next  = (phase_reg == PH_CLASS) ? KIND_CLASS
                                                                     : KIND_NAMETYPE;
                                err_next   = ERR_BAD_TAG;
                                we         = (phase_reg == PH_CLASS);
                                wdata      = fv_shift[AW-1:0];
                                cur_next   = cur_plus1;
                                bc_next    = '0;
                                fv_next    = '0;
                                phase_next = (cur_plus1 >= pool_reg) ? PH_FLAGS : PH_TAG;
                            end
                        end
                    end
                    PH_FLAGS:
                    begin
                        bc_next = bc_reg + 16'd1;
                        if (bc_reg == 16'd1)
                        begin
                            phase_next = PH_THIS;
                            bc_next    = '0;
                            fv_next    = '0;
                        end
                    end
                    PH_THIS:
                    begin
                        fv_next = fv_shift;
                        bc_next = bc_reg + 16'd1;
                        if (bc_reg == 16'd1)
                        begin
                            if ({1'b0, fv_shift} >= pool17)
                            begin
                                ov_next     = 1'b1;
                                kind_next   = KIND_ERROR;
                                idx_next    = 12'(fv_shift);
                                val_next    = fv_shift;
                                err_next    = ERR_RANGE;
                                phase_next  = PH_HUNT;
                                window_next = '0;
                                bc_next     = '0;
                            end
                            else
                            begin
                                phase_next = PH_LOOKUP;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next  = PH_HUNT;
                        window_next = '0;
                        bc_next     = '0;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            bc_reg     <= '0;
            cur_reg    <= '0;
            pool_reg   <= '0;
            long_reg   <= 1'b0;
            fv_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            bc_reg     <= bc_next;
            cur_reg    <= cur_next;
            pool_reg   <= pool_next;
            long_reg   <= long_next;
            fv_reg     <= fv_next;
            ov_reg     <= ov_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        err_reg  <= err_next;
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            table_mem[waddr] <= wdata;
        end
        rdata_reg <= table_mem[raddr];
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign entry_index = idx_reg;
    assign value       = val_reg;
    assign error_code  = err_reg;

    `CFCP_ASSERT_NOW(a_err_code_clean, ov_reg && kind_reg != KIND_ERROR,
        err_reg == ERR_BAD_TAG, "error code set on a non-error record")
    `CFCP_ASSERT_NEXT(a_lookup_done, phase_reg == PH_LOOKUP && step,
        phase_reg == PH_HUNT && ov_reg, "lookup did not finish")
    `CFCP_ASSERT_NEXT(a_out_hold, ov_reg && !out_ready, ov_reg && $stable(val_reg),
        "pending record changed")

endmodule

[design/class_file_constant_pool_parser_top.sv]
// Byte-serial class-file constant pool parser. One byte (or an end mark) is taken per
// transaction and at most one record comes out for it; the sustained rate is one byte per
// cycle while records are accepted, set by the single-step parser loop. The only extra step
// is after the this_class index, where the parser waits in a lookup step for the registered
// read of the class table before the this_class record. A two-entry queue separates input
// classification from parsing, and each record sits in an output register; while a record
// waits unaccepted the parser stalls and the queue takes up to two more bytes. The class
// table needs no clearing after reset: each entry that the lookup reads is written first.
module class_file_constant_pool_parser_top
    import cfcp_pkg::*;
#(
    parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_mark,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [11:0] entry_index,
    output logic [15:0] value,
    output logic [2:0]  error_code
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // input classification and queue
    cfcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .end_mark  (end_mark),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    // parser and class table
    cfcp_back #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .entry_index (entry_index),
        .value       (value),
        .error_code  (error_code)
    );

endmodule

[bench/tb.sv]
module tb;
    import cfcp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH = 4096;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned STIM_ITEMS = 650;

    typedef struct {
        logic [2:0]  kind;
        logic [11:0] idx;
        logic [15:0] val;
        logic [2:0]  err;
    } record_t;

    // tracks the parser state and queues the records it should emit
    class pool_scoreboard;
        phase_t      ph;
        logic [31:0] window;
        int unsigned cnt;
        int unsigned entry;
        int unsigned pool_cnt;
        int unsigned fval;
        logic [7:0]  tag;
        int unsigned class_names[TABLE_DEPTH];
        record_t     pending[$];
        int          mismatches;

        function new();
            ph = PH_HUNT;
            window = '0;
        endfunction

        function void hunt();
            ph = PH_HUNT;
            window = '0;
            cnt = 0;
        endfunction

        function void push(logic [2:0] k, int unsigned i, int unsigned v, logic [2:0] e);
            record_t r;
            r.kind = k;
            r.idx = i[11:0];
            r.val = v[15:0];
            r.err = e;
            pending.push_back(r);
        endfunction

        function void abort(int unsigned i, int unsigned v, logic [2:0] e);
            hunt();
            push(KIND_ERROR, i, v, e);
        endfunction

        function void store(int unsigned i, int unsigned v);
            if (i < pool_cnt && i < TABLE_DEPTH)
                class_names[i] = v & 16'hFFFF;
        endfunction

        function void next_entry(int unsigned step);
            entry += step;
            cnt = 0;
            fval = 0;
            ph = (entry >= pool_cnt) ? PH_FLAGS : PH_TAG;
        endfunction

        // one accepted byte or end mark
        function void note(logic [7:0] b, logic e);
            int unsigned i;
            int unsigned nm;
            if (e)
            begin
                if (ph == PH_HUNT)
                    window = '0;
                else
                    abort(entry, 0, ERR_TRUNC);
                return;
            end
            case (ph)
                PH_HUNT:
                begin
                    window = {window[23:0], b};
                    if (window == MAGIC_WORD)
                    begin
                        ph = PH_VERSION;
                        cnt = 0;
                        entry = 0;
                        fval = 0;
                    end
                end
                PH_VERSION:
                begin
                    cnt++;
                    if (cnt >= 4)
                    begin
                        ph = PH_COUNT;
                        cnt = 0;
                        fval = 0;
                    end
                end
                PH_COUNT:
                begin
                    fval = ((fval << 8) | b) & 16'hFFFF;
                    cnt++;
                    if (cnt >= 2)
                    begin
                        if (fval > TABLE_DEPTH)
                        begin
                            pool_cnt = 0;
                            abort(0, 0, ERR_TOO_BIG);
                        end
                        else
                        begin
                            pool_cnt = fval;
                            entry = 0;
                            next_entry(1);
                        end
                    end
                end
                PH_TAG:
                begin
                    tag = b;
                    store(entry, 0);
                    cnt = 0;
                    fval = 0;
                    case (b)
                        TAG_UTF8: ph = PH_TEXT_LEN;
                        TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF:
                        begin
                            cnt = 4;
                            ph = PH_SKIP;
                        end
                        TAG_LONG, TAG_DOUBLE:
                        begin
                            store(entry + 1, 0);
                            cnt = 8;
                            ph = PH_SKIP;
                        end
                        TAG_CLASS: ph = PH_CLASS;
                        TAG_STRING:
                        begin
                            cnt = 2;
                            ph = PH_SKIP;
                        end
                        TAG_NAMETYPE: ph = PH_NAMETYPE;
                        default: abort(entry, b, ERR_BAD_TAG);
                    endcase
                end
                PH_SKIP:
                begin
                    if (cnt > 0)
                        cnt--;
                    if (cnt == 0)
                        next_entry((tag == TAG_LONG || tag == TAG_DOUBLE) ? 2 : 1);
                end
                PH_TEXT_LEN:
                begin
                    fval = ((fval << 8) | b) & 16'hFFFF;
                    cnt++;
                    if (cnt >= 2)
                    begin
                        push(KIND_TEXT_HDR, entry, fval, 3'd0);
                        if (fval == 0)
                            next_entry(1);
                        else
                        begin
                            cnt = fval;
                            ph = PH_TEXT_BYTES;
                        end
                    end
                end
                PH_TEXT_BYTES:
                begin
                    i = entry;
                    if (cnt > 0)
                        cnt--;
                    if (cnt == 0)
                        next_entry(1);
                    push(KIND_TEXT_BYTE, i, b, 3'd0);
                end
                PH_CLASS:
                begin
                    fval = ((fval << 8) | b) & 16'hFFFF;
                    cnt++;
                    if (cnt >= 2)
                    begin
                        if (fval >= pool_cnt)
                            abort(entry, fval, ERR_RANGE);
                        else
                        begin
                            i = entry;
                            nm = fval;
                            store(i, nm);
                            next_entry(1);
                            push(KIND_CLASS, i, nm, 3'd0);
                        end
                    end
                end
                PH_NAMETYPE:
                begin
                    fval = ((fval << 8) | b) & 16'hFFFF;
                    cnt++;
                    if (cnt >= 4)
                    begin
                        if (fval >= pool_cnt)
                            abort(entry, fval, ERR_RANGE);
                        else
                        begin
                            i = entry;
                            nm = fval;
                            next_entry(1);
                            push(KIND_NAMETYPE, i, nm, 3'd0);
                        end
                    end
                end
                PH_FLAGS:
                begin
                    cnt++;
                    if (cnt >= 2)
                    begin
                        ph = PH_THIS;
                        cnt = 0;
                        fval = 0;
                    end
                end
                PH_THIS:
                begin
                    fval = ((fval << 8) | b) & 16'hFFFF;
                    cnt++;
                    if (cnt >= 2)
                    begin
                        i = fval;
                        if (i >= pool_cnt)
                            abort(i, i, ERR_RANGE);
                        else
                        begin
                            nm = (i != 0) ? class_names[i] : 0;
                            if (nm == 0)
                                abort(i, 0, ERR_NOT_CLASS);
                            else
                            begin
                                hunt();
                                push(KIND_THIS, i, nm, 3'd0);
                            end
                        end
                    end
                end
                default: hunt();
            endcase
        endfunction

        function void report(string what, int unsigned exp_v, int unsigned got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, got_v,
                         $realtime);
        endfunction

        // one accepted output record
        function void check(record_t got);
            record_t exp_r;
            if (pending.size() == 0)
            begin
                report("unexpected record kind", 0, got.kind);
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind)
                report("kind", exp_r.kind, got.kind);
            if (got.idx !== exp_r.idx)
                report("entry_index", exp_r.idx, got.idx);
            if (got.val !== exp_r.val)
                report("value", exp_r.val, got.val);
            if (got.err !== exp_r.err)
                report("error_code", exp_r.err, got.err);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_mark;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [11:0] entry_index;
    logic [15:0] value;
    logic [2:0]  error_code;

    pool_scoreboard sb = new();
    logic [7:0]     stim_b[$];
    logic           stim_e[$];
    bit             idle_on;
    int unsigned    stall_left;
    int unsigned    quiet;

    class_file_constant_pool_parser_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .end_mark(end_mark),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .entry_index(entry_index),
        .value(value),
        .error_code(error_code)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void put(logic [7:0] b, logic e = 1'b0);
        stim_b.push_back(b);
        stim_e.push_back(e);
    endfunction

    function automatic void put16(int unsigned v);
        put(v[15:8]);
        put(v[7:0]);
    endfunction

    // magic, version and pool count
    function automatic void file_head(int unsigned n);
        put(8'hCA);
        put(8'hFE);
        put(8'hBA);
        put(8'hBE);
        repeat (4)
            put(8'($urandom_range(0, 255)));
        put16(n);
    endfunction

    // well-formed pool with random content, optionally broken at one entry at most
    function automatic void build_file(int unsigned n, bit broken);
        int unsigned classes[$];
        int unsigned i;
        int unsigned bad_at;
        int unsigned len;
        logic [7:0]  skip_tags[5];
        skip_tags = '{TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF};
        bad_at = broken ? $urandom_range(1, (n > 1) ? n : 1) : 0;
        file_head(n);
        i = 1;
        while (i < n)
        begin
            if (i == bad_at)
            begin
                case ($urandom_range(0, 2))
                    0: put(($urandom_range(0, 1) == 0) ? 8'd2 : 8'($urandom_range(13, 255)));
                    1:
                    begin
                        put(TAG_CLASS);
                        put16(n + $urandom_range(0, 200));
                    end
                    default: put(8'h00, 1'b1);
                endcase
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0:
                    begin
                        put(TAG_UTF8);
                        len = $urandom_range(0, 4);
                        put16(len);
                        repeat (len)
                            put(8'($urandom_range(0, 255)));
                    end
                    1:
                    begin
                        put(skip_tags[$urandom_range(0, 4)]);
                        repeat (4)
                            put(8'($urandom_range(0, 255)));
                    end
                    2:
                    begin
                        put(($urandom_range(0, 1) == 0) ? TAG_LONG : TAG_DOUBLE);
                        repeat (8)
                            put(8'($urandom_range(0, 255)));
                        i++;
                    end
                    3:
                    begin
                        put(TAG_STRING);
                        put16($urandom_range(0, 65535));
                    end
                    4, 5:
                    begin
                        put(TAG_CLASS);
                        len = $urandom_range(0, n - 1);
                        put16(len);
                        if (len != 0)
                            classes.push_back(i);
                    end
                    default:
                    begin
                        put(TAG_NAMETYPE);
                        put16($urandom_range(0, 65535));
                        put16($urandom_range(0, n - 1));
                    end
                endcase
            end
            i++;
        end
        put16($urandom_range(0, 65535));
        if (classes.size() > 0 && $urandom_range(0, 3) != 0)
            put16(classes[$urandom_range(0, classes.size() - 1)]);
        else
            put16($urandom_range(0, n + 2));
    endfunction

    // sender: one transaction, valid held until accepted
    task automatic send(logic [7:0] b, logic e);
        int unsigned g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_mark <= e;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note(b, e);
    endtask

    // receiver with random stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    // output checking
    always @(posedge clk)
    begin
        record_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind = kind;
            got.idx = entry_index;
            got.val = value;
            got.err = error_code;
            sb.check(got);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int unsigned directed_len;
        int unsigned k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        end_mark = 1'b0;
        out_ready = 1'b0;
        idle_on = 1'b1;
        stall_left = 0;
        quiet = 0;

        // directed: end mark while hunting, empty pools, oversize pools, a full-size pool cut short
        put(8'h00, 1'b1);
        file_head(0);
        put16(0);
        put16(0);
        file_head(16'hFFFF);
        file_head(4097);
        file_head(4096);
        put(8'h00, 1'b1);
        file_head(1);
        put16(0);
        put16(0);
        // every tag class, empty text, double in the last slot, this_class found
        file_head(8);
        put(TAG_CLASS);
        put16(2);
        put(TAG_UTF8);
        put16(0);
        put(TAG_NAMETYPE);
        put16(16'hFFFF);
        put16(7);
        put(TAG_UTF8);
        put16(2);
        put(8'h00);
        put(8'hFF);
        put(TAG_STRING);
        put16(5);
        put(TAG_FLOAT);
        repeat (4)
            put(8'hFF);
        put(TAG_DOUBLE);
        repeat (8)
            put(8'h00);
        put16(16'hFFFF);
        put16(1);
        // bad tags, a range error, this_class not a class
        file_head(3);
        put(8'd2);
        file_head(3);
        put(8'hFF);
        file_head(3);
        put(TAG_NAMETYPE);
        put16(1);
        put16(3);
        file_head(3);
        put(TAG_CLASS);
        put16(0);
        put(TAG_INTEGER);
        repeat (4)
            put(8'h55);
        put16(0);
        put16(1);
        file_head(3);
        put(TAG_CLASS);
        put16(2);
        put(TAG_LONG);
        repeat (8)
            put(8'hAA);
        put16(0);
        put16(2);
        directed_len = stim_b.size();

        // random: mostly well-formed files, some broken ones and noise
        while (stim_b.size() < STIM_ITEMS)
        begin
            k = $urandom_range(0, 99);
            if (k < 60)
                build_file(($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                       : $urandom_range(0, 8), 1'b0);
            else if (k < 85)
                build_file($urandom_range(1, 8), 1'b1);
            else if (k < 95)
                repeat ($urandom_range(3, 12))
                    put(($urandom_range(0, 3) == 0) ? 8'hCA : 8'($urandom_range(0, 255)));
            else
                put(8'($urandom_range(0, 255)), 1'b1);
        end

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int unsigned n = 0; n < stim_b.size(); n++)
        begin
            // hold off until the parser has drained
            if (n == directed_len)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send(stim_b[n], stim_e[n]);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/cfcp_pkg.sv
design/cfcp_front.sv
design/cfcp_back.sv
design/class_file_constant_pool_parser_top.sv
bench/tb.sv
